[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// Assertion macros shared by the allocator RTL.
// Define NO_ASSERTIONS to compile them away.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FFBA_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error("assertion failed");
`define FFBA_NEVER(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) else $error("forbidden condition");
`else
`define FFBA_ASSERT(lbl, clk, rstn, prop)
`define FFBA_NEVER(lbl, clk, rstn, expr)
`endif
`endif

[src/ffba_pkg.sv]
// ----------------------------------------------------------------------------
// ffba_pkg
// Types and constants of the first-fit block allocator.
// ----------------------------------------------------------------------------
package ffba_pkg;

  localparam int MAX_BLOCKS_DEF   = 64;
  localparam int HEADER_BYTES_DEF = 24;

  localparam logic [31:0] HEAP_LIMIT_RST = 32'd16777216;
  localparam logic [24:0] GROW_MIN_RST   = 25'd65536;
  localparam int          ALIGN          = 16;

  localparam int IN_W  = 72;
  localparam int OUT_W = 72;

  localparam logic [1:0] CMD_ALLOC   = 2'd0;
  localparam logic [1:0] CMD_FREE    = 2'd1;
  localparam logic [1:0] CMD_REALLOC = 2'd2;
  localparam logic [1:0] CMD_RSVD    = 2'd3;

  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_ZERO    = 3'd1;
  localparam logic [2:0] ST_NOSPACE = 3'd2;
  localparam logic [2:0] ST_FULL    = 3'd3;
  localparam logic [2:0] ST_UNKNOWN = 3'd4;

  localparam logic CFG_HEAP_LIMIT = 1'b0;
  localparam logic CFG_GROW_MIN   = 1'b1;

  typedef struct packed {
    logic [31:0] off;
    logic [31:0] size;
    logic        is_free;
  } entry_t;

endpackage

[src/first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// first_fit_block_allocator
// Table lookups and scan steps read one entry at a time, and an insert or a merge
// moves entries one at a time, all through the one read port and the one write port
// of the table memory.
// One command is processed at a time; its result word waits in an output register.
// Reset empties the table and the break at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module first_fit_block_allocator #(
  parameter int MAX_BLOCKS   = ffba_pkg::MAX_BLOCKS_DEF,
  parameter int HEADER_BYTES = ffba_pkg::HEADER_BYTES_DEF
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     cfg_we_i,
  input  logic                     cfg_idx_i,
  input  logic [31:0]              cfg_data_i,
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  // cmd[1:0], req_size[33:2], block_addr[65:34], zero pad.
  input  logic [ffba_pkg::IN_W-1:0]  s_axis_tdata,
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  // status[2:0], result_addr[34:3], copy_len[66:35], zero pad.
  output logic [ffba_pkg::OUT_W-1:0] m_axis_tdata
);

  localparam int CW = $clog2(MAX_BLOCKS + 1);
  localparam int IW = $clog2(MAX_BLOCKS);
  localparam logic [CW-1:0] MAXC = CW'(MAX_BLOCKS);
  localparam logic [33:0]   H34  = 34'(HEADER_BYTES);
  localparam logic [33:0]   A34  = 34'(ffba_pkg::ALIGN);

  localparam logic [3:0] S_IDLE = 4'd0, S_FIND_RD = 4'd1, S_FIND_CHK = 4'd2,
    S_ALLOC_RD = 4'd3, S_ALLOC_CHK = 4'd4, S_GROW = 4'd5, S_SH_RD = 4'd6,
    S_SH_WR = 4'd7, S_INS = 4'd8, S_ALLOC_END = 4'd9, S_MRG_RD = 4'd10,
    S_MRG_CHK = 4'd11, S_DROP_RD = 4'd12, S_DROP_WR = 4'd13, S_DONE = 4'd14;

  ffba_pkg::entry_t mem [MAX_BLOCKS];
  ffba_pkg::entry_t rd_q, wdata, ins_d, ins_q, cur_d, cur_q, sur_d, sur_q;
  logic [IW-1:0] raddr, waddr;
  logic mem_we;

  logic [3:0] state_d, state_q;
  logic [CW-1:0] cnt_d, cnt_q, idx_d, idx_q, j_d, j_q, pos_d, pos_q;
  logic [31:0] brk_d, brk_q, lim_d, lim_q;
  logic [24:0] gmin_d, gmin_q;
  logic [1:0] cmd_d, cmd_q;
  logic [31:0] req_d, req_q, p_d, p_q, oldsz_d, oldsz_q;
  logic [32:0] n_d, n_q;
  logic move_d, move_q, ph2_d, ph2_q, spend_d, spend_q;
  logic [2:0] rst_d, rst_q;
  logic [31:0] raddr_d, raddr_q, rcopy_d, rcopy_q;
  logic mv_d, mv_q;
  logic [ffba_pkg::OUT_W-1:0] md_d, md_q;

  logic [33:0] need, grow_r, merged_end;
  logic [34:0] grow;
  logic [35:0] want;
  logic [32:0] req33;

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[waddr] <= wdata;
    end
    rd_q <= mem[raddr];
  end

  assign req33      = {1'b0, s_axis_tdata[33:2]};
  assign need       = {1'b0, n_q} + H34;
  assign grow_r     = (need + 34'd15) & ~34'd15;
  assign grow       = (need < {9'd0, gmin_q}) ? {10'd0, gmin_q} : {1'b0, grow_r};
  assign want       = {4'd0, brk_q} + {1'b0, grow};
  assign merged_end = {2'd0, cur_q.off} + H34 + {2'd0, cur_q.size};

  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = mv_q;
  assign m_axis_tdata  = md_q;

  always_comb begin
    state_d = state_q; cnt_d = cnt_q; idx_d = idx_q; j_d = j_q; pos_d = pos_q;
    brk_d = brk_q; lim_d = lim_q; gmin_d = gmin_q; cmd_d = cmd_q; req_d = req_q;
    p_d = p_q; oldsz_d = oldsz_q; n_d = n_q; move_d = move_q; ph2_d = ph2_q;
    spend_d = spend_q; rst_d = rst_q; raddr_d = raddr_q; rcopy_d = rcopy_q;
    mv_d = mv_q; md_d = md_q; ins_d = ins_q; cur_d = cur_q; sur_d = sur_q;
    raddr = '0; waddr = '0; wdata = rd_q; mem_we = 1'b0;

    if (cfg_we_i) begin
      if (cfg_idx_i == ffba_pkg::CFG_HEAP_LIMIT) begin
        lim_d = cfg_data_i;
      end else begin
        gmin_d = cfg_data_i[24:0];
      end
    end
    if (mv_q && m_axis_tready) begin
      mv_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          cmd_d = s_axis_tdata[1:0];
          req_d = s_axis_tdata[33:2];
          p_d = s_axis_tdata[65:34];
          n_d = (req33 + 33'd15) & ~33'd15;
          idx_d = '0; move_d = 1'b0; ph2_d = 1'b0; spend_d = 1'b0;
          rst_d = ffba_pkg::ST_OK; raddr_d = '0; rcopy_d = '0;
          state_d = S_DONE;
          if (s_axis_tdata[1:0] == ffba_pkg::CMD_FREE) begin
            if (s_axis_tdata[65:34] != '0) state_d = S_FIND_RD;
          end else if (s_axis_tdata[1:0] == ffba_pkg::CMD_ALLOC ||
                       s_axis_tdata[1:0] == ffba_pkg::CMD_REALLOC) begin
            if (s_axis_tdata[1:0] == ffba_pkg::CMD_REALLOC && s_axis_tdata[65:34] != '0) begin
              state_d = S_FIND_RD;
            end else if (s_axis_tdata[33:2] == '0) begin
              rst_d = ffba_pkg::ST_ZERO;
            end else begin
              state_d = S_ALLOC_RD;
            end
          end
        end
      end
      S_FIND_RD: begin
        if (idx_q == cnt_q) begin
          if (!ph2_q) rst_d = ffba_pkg::ST_UNKNOWN;
          state_d = S_DONE;
        end else begin
          raddr = idx_q[IW-1:0];
          state_d = S_FIND_CHK;
        end
      end
      S_FIND_CHK: begin
        if ({2'd0, rd_q.off} + H34 == {2'd0, p_q}) begin
          if (ph2_q || cmd_q == ffba_pkg::CMD_FREE || req_q == '0) begin
            cur_d = rd_q; cur_d.is_free = 1'b1;
            wdata = cur_d; waddr = idx_q[IW-1:0]; mem_we = 1'b1;
            state_d = S_MRG_RD;
          end else if (rd_q.size >= req_q) begin
            raddr_d = p_q;
            state_d = S_DONE;
          end else begin
            oldsz_d = rd_q.size; move_d = 1'b1; idx_d = '0;
            state_d = S_ALLOC_RD;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_FIND_RD;
        end
      end
      S_ALLOC_RD: begin
        if (idx_q == cnt_q) begin
          state_d = S_GROW;
        end else begin
          raddr = idx_q[IW-1:0];
          state_d = S_ALLOC_CHK;
        end
      end
      S_ALLOC_CHK: begin
        if (rd_q.is_free && {1'b0, rd_q.size} >= n_q) begin
          raddr_d = rd_q.off + 32'(HEADER_BYTES);
          waddr = idx_q[IW-1:0]; mem_we = 1'b1;
          wdata = rd_q; wdata.is_free = 1'b0;
          state_d = S_ALLOC_END;
          if ({2'd0, rd_q.size} >= {1'b0, n_q} + H34 + A34 && cnt_q < MAXC) begin
            wdata.size = n_q[31:0];
            ins_d.off = rd_q.off + 32'(HEADER_BYTES) + n_q[31:0];
            ins_d.size = rd_q.size - n_q[31:0] - 32'(HEADER_BYTES);
            ins_d.is_free = 1'b1;
            pos_d = idx_q + 1'b1; j_d = cnt_q;
            state_d = S_SH_RD;
          end
        end else begin
          idx_d = idx_q + 1'b1;
          state_d = S_ALLOC_RD;
        end
      end
      S_GROW: begin
        state_d = S_DONE;
        if (cnt_q >= MAXC) begin
          rst_d = ffba_pkg::ST_FULL;
        end else if (want > {4'd0, lim_q}) begin
          rst_d = ffba_pkg::ST_NOSPACE;
        end else begin
          brk_d = want[31:0];
          raddr_d = brk_q + 32'(HEADER_BYTES);
          ins_d.off = brk_q; ins_d.size = n_q[31:0]; ins_d.is_free = 1'b0;
          pos_d = cnt_q; j_d = cnt_q;
          spend_d = grow >= {1'b0, need + H34 + A34};
          sur_d.off = brk_q + need[31:0];
          sur_d.size = grow[31:0] - need[31:0] - 32'(HEADER_BYTES);
          sur_d.is_free = 1'b1;
          state_d = S_SH_RD;
        end
      end
      S_SH_RD: begin
        if (j_q == pos_q) begin
          state_d = S_INS;
        end else begin
          raddr = IW'(j_q - 1'b1);
          state_d = S_SH_WR;
        end
      end
      S_SH_WR: begin
        waddr = j_q[IW-1:0]; mem_we = 1'b1;
        j_d = j_q - 1'b1;
        state_d = S_SH_RD;
      end
      S_INS: begin
        waddr = pos_q[IW-1:0]; wdata = ins_q; mem_we = 1'b1;
        cnt_d = cnt_q + 1'b1;
        state_d = S_ALLOC_END;
      end
      S_ALLOC_END: begin
        if (spend_q) begin
          spend_d = 1'b0;
          if (cnt_q < MAXC) begin
            ins_d = sur_q; pos_d = cnt_q; j_d = cnt_q;
            state_d = S_SH_RD;
          end
        end else if (move_q) begin
          rcopy_d = oldsz_q; ph2_d = 1'b1; move_d = 1'b0; idx_d = '0;
          state_d = S_FIND_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MRG_RD: begin
        if (idx_q + 1'b1 < cnt_q) begin
          raddr = IW'(idx_q + 1'b1);
          state_d = S_MRG_CHK;
        end else begin
          state_d = S_DONE;
        end
      end
      S_MRG_CHK: begin
        if (rd_q.is_free && {2'd0, rd_q.off} == merged_end) begin
          cur_d.size = cur_q.size + 32'(HEADER_BYTES) + rd_q.size;
          wdata = cur_d; waddr = idx_q[IW-1:0]; mem_we = 1'b1;
          j_d = idx_q + 1'b1;
          state_d = S_DROP_RD;
        end else begin
          state_d = S_DONE;
        end
      end
      S_DROP_RD: begin
        if (j_q + 1'b1 < cnt_q) begin
          raddr = IW'(j_q + 1'b1);
          state_d = S_DROP_WR;
        end else begin
          cnt_d = cnt_q - 1'b1;
          state_d = S_MRG_RD;
        end
      end
      S_DROP_WR: begin
        waddr = j_q[IW-1:0]; mem_we = 1'b1;
        j_d = j_q + 1'b1;
        state_d = S_DROP_RD;
      end
      S_DONE: begin
        if (!mv_q || m_axis_tready) begin
          mv_d = 1'b1;
          md_d = {5'd0, rcopy_q, raddr_q, rst_q};
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      brk_q   <= '0;
      lim_q   <= ffba_pkg::HEAP_LIMIT_RST;
      gmin_q  <= ffba_pkg::GROW_MIN_RST;
      mv_q    <= 1'b0;
      move_q  <= 1'b0;
      ph2_q   <= 1'b0;
      spend_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      brk_q   <= brk_d;
      lim_q   <= lim_d;
      gmin_q  <= gmin_d;
      mv_q    <= mv_d;
      move_q  <= move_d;
      ph2_q   <= ph2_d;
      spend_q <= spend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q <= idx_d; j_q <= j_d; pos_q <= pos_d; cmd_q <= cmd_d; req_q <= req_d;
    p_q <= p_d; oldsz_q <= oldsz_d; n_q <= n_d; rst_q <= rst_d;
    raddr_q <= raddr_d; rcopy_q <= rcopy_d; md_q <= md_d;
    ins_q <= ins_d; cur_q <= cur_d; sur_q <= sur_d;
  end

  `FFBA_ASSERT(a_count_bound, clk_i, rst_ni, cnt_q <= MAXC)
  `FFBA_ASSERT(a_accept_busy, clk_i, rst_ni, (s_axis_tvalid && s_axis_tready) |=> state_q != S_IDLE)
  `FFBA_NEVER(a_no_idle_write, clk_i, rst_ni, mem_we && state_q == S_IDLE)

endmodule

[verif/tb_first_fit_block_allocator.sv]
// ----------------------------------------------------------------------------
// tb_first_fit_block_allocator
// Self-checking testbench for the first-fit block allocator. A scoreboard
// keeps its own copy of the block table, the break and the registers, works
// out the answer to each accepted command and compares it field by field with
// the result words. Directed commands come first, then random alloc, free, realloc and
// reserved traffic over several register settings, idling on both sides except the last.
// ----------------------------------------------------------------------------
module tb_first_fit_block_allocator;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NBLK = ffba_pkg::MAX_BLOCKS_DEF;
  localparam int HDR = ffba_pkg::HEADER_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 20000;

  typedef struct {
    logic [2:0]  status;
    logic [31:0] addr;
    logic [31:0] copy;
  } answer_t;

  class alloc_scoreboard;
    logic [31:0] blk_off[NBLK];
    logic [31:0] blk_size[NBLK];
    bit          blk_free[NBLK];
    int          blk_cnt;
    logic [31:0] brk;
    logic [31:0] limit;
    logic [31:0] min_step;
    answer_t     pending_q[$];
    int          errors;

    function new();
      blk_cnt = 0;
      brk = 0;
      limit = ffba_pkg::HEAP_LIMIT_RST;
      min_step = 32'(ffba_pkg::GROW_MIN_RST);
      errors = 0;
    endfunction

    function void insert_blk(int pos, logic [63:0] off, logic [63:0] size, bit fr);
      if (blk_cnt >= NBLK || pos > blk_cnt) return;
      for (int k = blk_cnt; k > pos; k--) begin
        blk_off[k] = blk_off[k-1];
        blk_size[k] = blk_size[k-1];
        blk_free[k] = blk_free[k-1];
      end
      blk_off[pos] = off[31:0];
      blk_size[pos] = size[31:0];
      blk_free[pos] = fr;
      blk_cnt++;
    endfunction

    function void remove_blk(int pos);
      for (int k = pos; k < blk_cnt - 1; k++) begin
        blk_off[k] = blk_off[k+1];
        blk_size[k] = blk_size[k+1];
        blk_free[k] = blk_free[k+1];
      end
      blk_cnt--;
    endfunction

    function int lookup(logic [63:0] p);
      for (int k = 0; k < blk_cnt; k++)
        if (64'(blk_off[k]) + HDR == p) return k;
      return -1;
    endfunction

    function logic [63:0] round_up(logic [63:0] n);
      return (n + 15) & ~64'd15;
    endfunction

    function logic [2:0] take_block(logic [63:0] req, output logic [63:0] addr);
      logic [63:0] n, need, grow, want, old;
      addr = 0;
      if (req == 0) return ffba_pkg::ST_ZERO;
      n = round_up(req);
      for (int k = 0; k < blk_cnt; k++) begin
        if (!blk_free[k] || 64'(blk_size[k]) < n) continue;
        if (64'(blk_size[k]) >= n + HDR + 16 && blk_cnt < NBLK) begin
          insert_blk(k + 1, 64'(blk_off[k]) + HDR + n, 64'(blk_size[k]) - n - HDR, 1'b1);
          blk_size[k] = n[31:0];
        end
        blk_free[k] = 1'b0;
        addr = 64'(blk_off[k]) + HDR;
        return ffba_pkg::ST_OK;
      end
      if (blk_cnt >= NBLK) return ffba_pkg::ST_FULL;
      need = n + HDR;
      grow = (need < 64'(min_step)) ? 64'(min_step) : round_up(need);
      old = 64'(brk);
      want = old + grow;
      if (want > 64'(limit)) return ffba_pkg::ST_NOSPACE;
      insert_blk(blk_cnt, old, n, 1'b0);
      if (grow >= need + HDR + 16 && blk_cnt < NBLK)
        insert_blk(blk_cnt, old + need, grow - need - HDR, 1'b1);
      brk = want[31:0];
      addr = old + HDR;
      return ffba_pkg::ST_OK;
    endfunction

    function void release_blk(int k);
      blk_free[k] = 1'b1;
      while (k + 1 < blk_cnt && blk_free[k+1] &&
             64'(blk_off[k+1]) == 64'(blk_off[k]) + HDR + 64'(blk_size[k])) begin
        blk_size[k] = blk_size[k] + HDR + blk_size[k+1];
        remove_blk(k + 1);
      end
    endfunction

    function void note_command(logic [1:0] cmd, logic [31:0] req, logic [31:0] p);
      answer_t a;
      logic [63:0] na, oldsize;
      int b;
      a.status = ffba_pkg::ST_OK;
      a.addr = 0;
      a.copy = 0;
      na = 0;
      if (cmd == ffba_pkg::CMD_ALLOC) begin
        a.status = take_block(64'(req), na);
      end else if (cmd == ffba_pkg::CMD_FREE) begin
        if (p != 0) begin
          b = lookup(64'(p));
          if (b < 0) a.status = ffba_pkg::ST_UNKNOWN;
          else release_blk(b);
        end
      end else if (cmd == ffba_pkg::CMD_REALLOC) begin
        if (p == 0) begin
          a.status = take_block(64'(req), na);
        end else begin
          b = lookup(64'(p));
          if (b < 0) a.status = ffba_pkg::ST_UNKNOWN;
          else if (req == 0) release_blk(b);
          else if (blk_size[b] >= req) na = 64'(p);
          else begin
            oldsize = 64'(blk_size[b]);
            a.status = take_block(64'(req), na);
            if (a.status == ffba_pkg::ST_OK) begin
              b = lookup(64'(p));
              if (b >= 0) release_blk(b);
              a.copy = oldsize[31:0];
            end
          end
        end
      end
      a.addr = na[31:0];
      pending_q.push_back(a);
    endfunction

    function void check_word(logic [2:0] st, logic [31:0] addr, logic [31:0] copy);
      answer_t e;
      if (pending_q.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word: status=%0d addr=%h copy=%h", st, addr, copy);
        return;
      end
      e = pending_q.pop_front();
      if (st !== e.status || addr !== e.addr || copy !== e.copy) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected status=%0d addr=%h copy=%h, got status=%0d addr=%h copy=%h",
                   e.status, e.addr, e.copy, st, addr, copy);
      end
    endfunction

    // Payload offset of a random block; busy ones only unless any is asked for.
    function logic [31:0] pick_block(bit any);
      int idx[$];
      for (int k = 0; k < blk_cnt; k++)
        if (any || !blk_free[k]) idx.push_back(k);
      if (idx.size() == 0) return 0;
      return blk_off[idx[$urandom_range(0, idx.size() - 1)]] + HDR;
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic cfg_we_i, cfg_idx_i;
  logic [31:0] cfg_data_i;
  logic s_axis_tvalid, s_axis_tready;
  logic [ffba_pkg::IN_W-1:0] s_axis_tdata;
  logic m_axis_tvalid, m_axis_tready;
  logic [ffba_pkg::OUT_W-1:0] m_axis_tdata;

  alloc_scoreboard sb;
  bit idle_ok;
  bit pressure_req;
  int hold_cnt;
  int stall_cycles;

  first_fit_block_allocator DUT (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i), .cfg_idx_i(cfg_idx_i), .cfg_data_i(cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  always begin
    clk_i = 1'b1;
    #5;
    clk_i = 1'b0;
    #5;
  end

  initial begin
    m_axis_tready = 1'b0;
    hold_cnt = 0;
    forever begin
      @(posedge clk_i);
      if (hold_cnt > 0) begin
        hold_cnt--;
        m_axis_tready <= 1'b0;
      end else if (pressure_req) begin
        pressure_req = 1'b0;
        hold_cnt = 400;
        m_axis_tready <= 1'b0;
      end else if (idle_ok && $urandom_range(0, 7) == 0) begin
        hold_cnt = $urandom_range(1, 11) - 1;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_word(m_axis_tdata[2:0], m_axis_tdata[34:3], m_axis_tdata[66:35]);
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("tb_first_fit_block_allocator: FAIL");
      $finish;
    end
  end

  task automatic write_reg(logic idx, logic [31:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == ffba_pkg::CFG_HEAP_LIMIT) sb.limit = val;
    else sb.min_step = {7'd0, val[24:0]};
  endtask

  task automatic drain();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  task automatic send_word(logic [1:0] cmd, logic [31:0] req, logic [31:0] p);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {6'd0, p, req, cmd};
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_command(cmd, req, p);
    if (idle_ok && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk_i);
    end
  endtask

  task automatic close_stream();
    s_axis_tvalid <= 1'b0;
  endtask

  function automatic logic [31:0] rand_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 75) return $urandom_range(1, 256);
    if (r < 93) return $urandom_range(257, 100000);
    if (r < 96) return 0;
    return $urandom();
  endfunction

  task automatic random_traffic(int n);
    int r;
    logic [1:0] c;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      c = ($urandom_range(0, 1) != 0) ? ffba_pkg::CMD_FREE : ffba_pkg::CMD_REALLOC;
      if (r < 45) send_word(ffba_pkg::CMD_ALLOC, rand_size(), 0);
      else if (r < 72) send_word(ffba_pkg::CMD_FREE, 0, sb.pick_block(1'b0));
      else if (r < 88) send_word(ffba_pkg::CMD_REALLOC, rand_size(), sb.pick_block(1'b0));
      else if (r < 91) send_word(ffba_pkg::CMD_FREE, 0, sb.pick_block(1'b1));
      else if (r < 95) send_word(c, rand_size(), $urandom());
      else if (r < 97) send_word(ffba_pkg::CMD_REALLOC, rand_size(), 0);
      else send_word(ffba_pkg::CMD_RSVD, $urandom(), $urandom());
    end
  endtask

  initial begin
    logic [31:0] a;
    sb = new();
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = ffba_pkg::CFG_HEAP_LIMIT;
    cfg_data_i = 0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    idle_ok = 1'b1;
    pressure_req = 1'b0;
    stall_cycles = 0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    send_word(ffba_pkg::CMD_ALLOC, 0, 0);
    send_word(ffba_pkg::CMD_ALLOC, 1, 0);
    send_word(ffba_pkg::CMD_ALLOC, 32'hFFFF_FFFF, 0);
    send_word(ffba_pkg::CMD_ALLOC, 100, 0);
    send_word(ffba_pkg::CMD_ALLOC, 40, 0);
    send_word(ffba_pkg::CMD_FREE, 0, 0);
    send_word(ffba_pkg::CMD_FREE, 0, 32'hFFFF_FFFF);
    send_word(ffba_pkg::CMD_FREE, 0, 32'd24);
    send_word(ffba_pkg::CMD_FREE, 0, 32'd24);
    send_word(ffba_pkg::CMD_REALLOC, 64, 0);
    a = sb.pick_block(1'b0);
    send_word(ffba_pkg::CMD_REALLOC, 8, a);
    send_word(ffba_pkg::CMD_REALLOC, 5000, a);
    send_word(ffba_pkg::CMD_REALLOC, 0, sb.pick_block(1'b0));
    send_word(ffba_pkg::CMD_REALLOC, 32'hFFFF_FFFF, sb.pick_block(1'b0));
    send_word(ffba_pkg::CMD_REALLOC, 16, 32'd7);
    send_word(ffba_pkg::CMD_RSVD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_word(ffba_pkg::CMD_ALLOC, 32'h7FFF_FFF0, 0);
    random_traffic(200);
    close_stream();
    drain();

    write_reg(ffba_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    write_reg(ffba_pkg::CFG_GROW_MIN, 32'd16);
    pressure_req = 1'b1;
    random_traffic(250);
    close_stream();
    drain();

    write_reg(ffba_pkg::CFG_HEAP_LIMIT, 32'd0);
    random_traffic(150);
    close_stream();
    drain();

    write_reg(ffba_pkg::CFG_HEAP_LIMIT, 32'h0200_0000);
    write_reg(ffba_pkg::CFG_GROW_MIN, 32'd16777216);
    random_traffic(200);
    close_stream();
    drain();

    write_reg(ffba_pkg::CFG_HEAP_LIMIT, 32'hFFFF_FFFF);
    write_reg(ffba_pkg::CFG_GROW_MIN, 32'd4096);
    idle_ok = 1'b0;
    random_traffic(300);
    close_stream();
    drain();
    repeat (600) @(posedge clk_i);

    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("tb_first_fit_block_allocator: PASS");
    end else begin
      $display("tb_first_fit_block_allocator: FAIL");
    end
    $finish;
  end
endmodule

[files.f]
+incdir+src
src/ffba_pkg.sv
src/first_fit_block_allocator.sv
verif/tb_first_fit_block_allocator.sv
